// ----- hdl/arp_resolver_with_pending_queue_macros.svh -----
// Assertion macros shared by the ARP resolver RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ARP_RESOLVER_WITH_PENDING_QUEUE_MACROS_SVH
`define ARP_RESOLVER_WITH_PENDING_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARP_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/arp_pkg.sv -----
// Package of the ARP resolver: field widths, codes, defaults and the result type.
// Depends on nothing; used by the interfaces, the output stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

	// Field widths of the channels.
	localparam int MAC_W  = 48;
	localparam int IP_W   = 32;
	localparam int TAG_W  = 16;
	localparam int TIME_W = 32;
	localparam int HOLD_W = 16;
	localparam int LIFE_W = 20;
	localparam int ELAP_W = 16;
	localparam int OPC_W  = 16;
	localparam int KIND_W = 3;
	localparam int ACT_W  = 2;
	localparam int FT_W   = 2;
	localparam int CIDX_W = 2;

	// Defaults of the structural parameters.
	localparam int CACHE_ENTRIES_DEF   = 16;
	localparam int REQUEST_ENTRIES_DEF = 16;
	localparam int QUEUE_DEPTH_DEF     = 16;
	localparam int TAG_BITS_DEF        = 16;

	// Results one item may cause at most.
	localparam int MAX_RESULTS = 16;
	localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(5000);
	localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(30000);
	localparam logic [MAC_W-1:0]  BCAST_MAC  = {MAC_W{1'b1}};

	// Actions of an input item.
	localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RECV = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

	// Frame types of a received frame.
	localparam logic [FT_W-1:0] FT_IPV4 = 2'd0;
	localparam logic [FT_W-1:0] FT_ARP  = 2'd1;

	localparam logic [OPC_W-1:0] OP_REPLY = 16'd2;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_MY_MAC = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MY_IP  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_HOLD   = 2'd2;
	localparam logic [CIDX_W-1:0] REG_LIFE   = 2'd3;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		K_IPV4    = 3'd0,
		K_REQ     = 3'd1,
		K_REPLY   = 3'd2,
		K_DELIVER = 3'd3,
		K_DROP    = 3'd4
	} kind_t;

	// One result beat.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MAC_W-1:0]  dst_mac;
		logic [IP_W-1:0]   target_ip;
		logic [MAC_W-1:0]  target_mac;
		logic [TAG_W-1:0]  out_tag;
		logic              last;
	} res_t;

	// Control from the sequencer to the output stage.
	typedef struct packed {
		logic emit;
		logic fin;
	} out_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/arp_if.sv -----
// Channel interfaces of the ARP resolver: input items, results, register writes.
// Depends on arp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface arp_item_if import arp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [IP_W-1:0]   hop_addr;
	logic [TAG_W-1:0]  datagram_tag;
	logic [FT_W-1:0]   frame_type;
	logic [MAC_W-1:0]  frame_dst_mac;
	logic [MAC_W-1:0]  frame_src_mac;
	logic              payload_ok;
	logic [OPC_W-1:0]  arp_opcode;
	logic [MAC_W-1:0]  arp_sender_mac;
	logic [IP_W-1:0]   arp_sender_ip;
	logic [IP_W-1:0]   arp_target_ip;
	logic [ELAP_W-1:0] elapsed_ms;

	modport source (output valid, action, hop_addr, datagram_tag, frame_type,
		frame_dst_mac, frame_src_mac, payload_ok, arp_opcode, arp_sender_mac,
		arp_sender_ip, arp_target_ip, elapsed_ms, input ready);
	modport sink (input valid, action, hop_addr, datagram_tag, frame_type,
		frame_dst_mac, frame_src_mac, payload_ok, arp_opcode, arp_sender_mac,
		arp_sender_ip, arp_target_ip, elapsed_ms, output ready);
endinterface

interface arp_result_if import arp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [MAC_W-1:0]  dst_mac;
	logic [IP_W-1:0]   target_ip;
	logic [MAC_W-1:0]  target_mac;
	logic [TAG_W-1:0]  out_tag;
	logic              last;

	modport source (output valid, kind, dst_mac, target_ip, target_mac, out_tag, last,
		input ready);
	modport sink (input valid, kind, dst_mac, target_ip, target_mac, out_tag, last,
		output ready);
endinterface

interface arp_cfg_if import arp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [MAC_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/arp_resolver_with_pending_queue.sv -----
// Top level of the ARP resolver: register file, sequencer, cache, request and
// queue memories. Depends on arp_pkg, arp_if, arp_ram, arp_out and the macro header.
//
// Channel  Role    Beat
// item     sink    one send, received frame or tick
// result   source  one result, last set on the final one of an item
// cfg      sink    one register write (index, data)
//
// A tick makes one pass over the cache memory, one entry a cycle.
// A send makes one pass over the cache memory and, on a miss, a further pass over the request table.
// A reply flush makes one cache pass per queued datagram.
// Reset is asynchronous; valid bits clear at once, so there is no clearing pass.
// Results sit in a stage and an output register; the next item is taken while they wait.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_resolver_with_pending_queue_macros.svh"

module arp_resolver_with_pending_queue import arp_pkg::*; #(
	parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
	parameter int REQUEST_ENTRIES = REQUEST_ENTRIES_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
	parameter int TAG_BITS        = TAG_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	arp_item_if.sink     item,
	arp_result_if.source result,
	arp_cfg_if.sink      cfg
);

	localparam int CIW  = $clog2(CACHE_ENTRIES);
	localparam int CCW  = $clog2(CACHE_ENTRIES + 1);
	localparam int RIW  = $clog2(REQUEST_ENTRIES);
	localparam int RCW  = $clog2(REQUEST_ENTRIES + 1);
	localparam int QIW  = $clog2(QUEUE_DEPTH);
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
	localparam int QTW  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int CDW  = IP_W + MAC_W + TIME_W;
	localparam int RDW  = IP_W + TIME_W;
	localparam int QDW  = QTW + IP_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CSCAN, S_RSCAN, S_SREQ, S_SQUEUE, S_LEARN, S_REPLY,
		S_HIT, S_DELIV, S_FRD, S_FWAIT, S_FDEC, S_FIN
	} state_t;

	typedef enum logic [2:0] {
		M_SEND, M_LEARN_BC, M_LEARN_RP, M_TICK, M_FLUSH
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	// Configuration registers.
	logic [MAC_W-1:0]  my_mac_q;
	logic [IP_W-1:0]   my_ip_q;
	logic [HOLD_W-1:0] hold_q;
	logic [LIFE_W-1:0] life_q;

	// Item and engine state.
	logic [TIME_W-1:0] now_q;
	logic [QCW-1:0]    qcount_q;
	logic [IP_W-1:0]   key_q;
	logic [QTW-1:0]    tag_q;
	logic [MAC_W-1:0]  smac_q;
	logic [MAC_W-1:0]  fsrc_q;
	logic [CACHE_ENTRIES-1:0]   cvalid_q;
	logic [REQUEST_ENTRIES-1:0] rvalid_q;

	// Cache pass.
	logic [CCW-1:0]    ci_q;
	logic [CIW-1:0]    ck_q;
	logic              ck_vld_q;
	logic              chit_q;
	logic [CIW-1:0]    chit_idx_q;
	logic [MAC_W-1:0]  chit_mac_q;
	logic              cold_vld_q;
	logic [CIW-1:0]    cold_idx_q;
	logic [TIME_W-1:0] cold_age_q;

	// Request table pass.
	logic [RCW-1:0]    ri_q;
	logic [RIW-1:0]    rk_q;
	logic              rk_vld_q;
	logic              rhit_q;
	logic [RIW-1:0]    rhit_idx_q;
	logic [TIME_W-1:0] rhit_time_q;
	logic              rold_vld_q;
	logic [RIW-1:0]    rold_idx_q;
	logic [TIME_W-1:0] rold_age_q;

	// Queue flush.
	logic [QCW-1:0]    qi_q;
	logic [QCW-1:0]    w_q;
	logic [QTW-1:0]    fl_tag_q;
	logic [NCNT_W-1:0] n_q;

	// Memory ports.
	logic           c_we;
	logic [CIW-1:0] c_waddr;
	logic [CDW-1:0] c_wdata;
	logic [CDW-1:0] c_rdata;
	logic           r_we;
	logic [RIW-1:0] r_waddr;
	logic [RDW-1:0] r_wdata;
	logic [RDW-1:0] r_rdata;
	logic           q_we;
	logic [QIW-1:0] q_waddr;
	logic [QDW-1:0] q_wdata;
	logic [QDW-1:0] q_rdata;

	logic [IP_W-1:0]   c_rd_ip;
	logic [MAC_W-1:0]  c_rd_mac;
	logic [TIME_W-1:0] c_rd_time;
	logic [TIME_W-1:0] c_age;
	logic [IP_W-1:0]   r_rd_ip;
	logic [TIME_W-1:0] r_rd_time;
	logic [TIME_W-1:0] r_age;

	logic           c_inv_any;
	logic [CIW-1:0] c_inv_idx;
	logic           r_inv_any;
	logic [RIW-1:0] r_inv_idx;
	logic [CIW-1:0] learn_idx;
	logic [RIW-1:0] rslot;
	logic           due;
	logic           qfull;
	logic           fl_emit;
	logic           accept;
	logic           bc_hit;
	logic           rp_hit;
	logic           dl_hit;

	out_ctl_t ctl;
	res_t     rin;
	logic     ack;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_mac_q <= '0;
			my_ip_q  <= '0;
			hold_q   <= HOLD_RESET;
			life_q   <= LIFE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MY_MAC: my_mac_q <= cfg.data;
				REG_MY_IP:  my_ip_q  <= cfg.data[IP_W-1:0];
				REG_HOLD:   hold_q   <= cfg.data[HOLD_W-1:0];
				REG_LIFE:   life_q   <= cfg.data[LIFE_W-1:0];
				default: ;
			endcase
		end
	end

	// Memory read data fields and ages.
	assign c_rd_ip   = c_rdata[CDW-1 -: IP_W];
	assign c_rd_mac  = c_rdata[TIME_W +: MAC_W];
	assign c_rd_time = c_rdata[TIME_W-1:0];
	assign c_age     = now_q - c_rd_time;
	assign r_rd_ip   = r_rdata[RDW-1 -: IP_W];
	assign r_rd_time = r_rdata[TIME_W-1:0];
	assign r_age     = now_q - r_rd_time;

	// Lowest free slot of each table.
	always_comb begin
		c_inv_any = 1'b0;
		c_inv_idx = '0;
		for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
			if (!cvalid_q[i]) begin
				c_inv_any = 1'b1;
				c_inv_idx = CIW'(i);
			end
		end
	end

	always_comb begin
		r_inv_any = 1'b0;
		r_inv_idx = '0;
		for (int i = REQUEST_ENTRIES - 1; i >= 0; i--) begin
			if (!rvalid_q[i]) begin
				r_inv_any = 1'b1;
				r_inv_idx = RIW'(i);
			end
		end
	end

	// Slot choice: matching entry, else free, else oldest.
	assign learn_idx = chit_q ? chit_idx_q : (c_inv_any ? c_inv_idx : cold_idx_q);
	assign rslot     = rhit_q ? rhit_idx_q : (r_inv_any ? r_inv_idx : rold_idx_q);
	assign due       = !rhit_q || ((now_q - rhit_time_q) > TIME_W'(hold_q));
	assign qfull     = qcount_q >= QCW'(QUEUE_DEPTH);
	assign fl_emit   = chit_q && (n_q < NCNT_W'(MAX_RESULTS));

	// Receive decisions on the live item.
	assign bc_hit = (item.frame_dst_mac == BCAST_MAC) && item.payload_ok
		&& (item.arp_target_ip == my_ip_q);
	assign rp_hit = (item.frame_dst_mac == my_mac_q) && item.payload_ok
		&& (item.arp_opcode == OP_REPLY) && (item.arp_target_ip == my_ip_q);
	assign dl_hit = (item.frame_dst_mac == my_mac_q) && item.payload_ok;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	// Memory write ports.
	assign c_we    = (state_q == S_LEARN);
	assign c_waddr = learn_idx;
	assign c_wdata = {key_q, smac_q, now_q};
	assign r_we    = (state_q == S_SREQ) && due && ack;
	assign r_waddr = rslot;
	assign r_wdata = {key_q, now_q};

	always_comb begin
		q_we    = 1'b0;
		q_waddr = w_q[QIW-1:0];
		q_wdata = {fl_tag_q, key_q};
		case (state_q)
			S_SQUEUE: begin
				q_we    = !qfull;
				q_waddr = qcount_q[QIW-1:0];
				q_wdata = {tag_q, key_q};
			end
			S_FDEC: begin
				q_we = !fl_emit;
			end
			default: ;
		endcase
	end

	// Result beats by state.
	always_comb begin
		ctl = '0;
		rin = '0;
		case (state_q)
			S_HIT: begin
				ctl.emit    = 1'b1;
				rin.kind    = K_IPV4;
				rin.dst_mac = chit_mac_q;
				rin.out_tag = TAG_W'(tag_q);
			end
			S_DELIV: begin
				ctl.emit    = 1'b1;
				rin.kind    = K_DELIVER;
				rin.out_tag = TAG_W'(tag_q);
			end
			S_REPLY: begin
				ctl.emit       = 1'b1;
				rin.kind       = K_REPLY;
				rin.dst_mac    = smac_q;
				rin.target_ip  = key_q;
				rin.target_mac = fsrc_q;
			end
			S_SREQ: begin
				ctl.emit      = due;
				rin.kind      = K_REQ;
				rin.dst_mac   = BCAST_MAC;
				rin.target_ip = key_q;
			end
			S_SQUEUE: begin
				ctl.emit    = qfull;
				rin.kind    = K_DROP;
				rin.out_tag = TAG_W'(tag_q);
			end
			S_FDEC: begin
				ctl.emit    = fl_emit;
				rin.kind    = K_IPV4;
				rin.dst_mac = chit_mac_q;
				rin.out_tag = TAG_W'(fl_tag_q);
			end
			S_FIN: begin
				ctl.fin = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer and scan datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_SEND;
			now_q       <= '0;
			qcount_q    <= '0;
			cvalid_q    <= '0;
			rvalid_q    <= '0;
			key_q       <= '0;
			tag_q       <= '0;
			smac_q      <= '0;
			fsrc_q      <= '0;
			ci_q        <= '0;
			ck_q        <= '0;
			ck_vld_q    <= 1'b0;
			chit_q      <= 1'b0;
			chit_idx_q  <= '0;
			chit_mac_q  <= '0;
			cold_vld_q  <= 1'b0;
			cold_idx_q  <= '0;
			cold_age_q  <= '0;
			ri_q        <= '0;
			rk_q        <= '0;
			rk_vld_q    <= 1'b0;
			rhit_q      <= 1'b0;
			rhit_idx_q  <= '0;
			rhit_time_q <= '0;
			rold_vld_q  <= 1'b0;
			rold_idx_q  <= '0;
			rold_age_q  <= '0;
			qi_q        <= '0;
			w_q         <= '0;
			fl_tag_q    <= '0;
			n_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q      <= (item.action == ACT_SEND) ? item.hop_addr
							: item.arp_sender_ip;
						tag_q      <= item.datagram_tag[QTW-1:0];
						smac_q     <= item.arp_sender_mac;
						fsrc_q     <= item.frame_src_mac;
						ci_q       <= '0;
						ck_vld_q   <= 1'b0;
						chit_q     <= 1'b0;
						cold_vld_q <= 1'b0;
						case (item.action)
							ACT_SEND: begin
								mode_q  <= M_SEND;
								state_q <= S_CSCAN;
							end
							ACT_RECV: begin
								if (item.frame_type == FT_ARP) begin
									if (bc_hit) begin
										mode_q  <= M_LEARN_BC;
										state_q <= S_CSCAN;
									end else if (rp_hit) begin
										mode_q  <= M_LEARN_RP;
										state_q <= S_CSCAN;
									end
								end else if (item.frame_type == FT_IPV4 && dl_hit) begin
									state_q <= S_DELIV;
								end
							end
							ACT_TICK: begin
								now_q   <= now_q + TIME_W'(item.elapsed_ms);
								mode_q  <= M_TICK;
								state_q <= S_CSCAN;
							end
							default: ;
						endcase
					end
				end

				// One cache entry read per cycle, each checked in the cycle after its read.
				S_CSCAN: begin
					if (ci_q < CCW'(CACHE_ENTRIES)) begin
						ci_q     <= ci_q + 1'b1;
						ck_q     <= ci_q[CIW-1:0];
						ck_vld_q <= 1'b1;
					end else begin
						ck_vld_q <= 1'b0;
					end
					if (ck_vld_q) begin
						if (mode_q == M_TICK) begin
							if (cvalid_q[ck_q] && (c_age > TIME_W'(life_q))) begin
								cvalid_q[ck_q] <= 1'b0;
							end
						end else begin
							if (cvalid_q[ck_q] && (c_rd_ip == key_q) && !chit_q) begin
								chit_q     <= 1'b1;
								chit_idx_q <= ck_q;
								chit_mac_q <= c_rd_mac;
							end
							if (!cold_vld_q || (c_age > cold_age_q)) begin
								cold_vld_q <= 1'b1;
								cold_idx_q <= ck_q;
								cold_age_q <= c_age;
							end
						end
					end
					if (ci_q == CCW'(CACHE_ENTRIES) && !ck_vld_q) begin
						case (mode_q)
							M_SEND: begin
								if (chit_q) begin
									state_q <= S_HIT;
								end else begin
									ri_q       <= '0;
									rk_vld_q   <= 1'b0;
									rhit_q     <= 1'b0;
									rold_vld_q <= 1'b0;
									state_q    <= S_RSCAN;
								end
							end
							M_LEARN_BC, M_LEARN_RP: state_q <= S_LEARN;
							M_FLUSH:                state_q <= S_FDEC;
							default:                state_q <= S_IDLE;
						endcase
					end
				end

				// Same walk over the request table.
				S_RSCAN: begin
					if (ri_q < RCW'(REQUEST_ENTRIES)) begin
						ri_q     <= ri_q + 1'b1;
						rk_q     <= ri_q[RIW-1:0];
						rk_vld_q <= 1'b1;
					end else begin
						rk_vld_q <= 1'b0;
					end
					if (rk_vld_q) begin
						if (rvalid_q[rk_q] && (r_rd_ip == key_q) && !rhit_q) begin
							rhit_q      <= 1'b1;
							rhit_idx_q  <= rk_q;
							rhit_time_q <= r_rd_time;
						end
						if (!rold_vld_q || (r_age > rold_age_q)) begin
							rold_vld_q <= 1'b1;
							rold_idx_q <= rk_q;
							rold_age_q <= r_age;
						end
					end
					if (ri_q == RCW'(REQUEST_ENTRIES) && !rk_vld_q) begin
						state_q <= S_SREQ;
					end
				end

				S_SREQ: begin
					if (!due) begin
						state_q <= S_SQUEUE;
					end else if (ack) begin
						rvalid_q[rslot] <= 1'b1;
						state_q         <= S_SQUEUE;
					end
				end

				S_SQUEUE: begin
					if (qfull) begin
						if (ack) begin
							state_q <= S_FIN;
						end
					end else begin
						qcount_q <= qcount_q + 1'b1;
						state_q  <= S_FIN;
					end
				end

				S_LEARN: begin
					cvalid_q[learn_idx] <= 1'b1;
					if (mode_q == M_LEARN_BC) begin
						state_q <= S_REPLY;
					end else begin
						qi_q    <= '0;
						w_q     <= '0;
						n_q     <= '0;
						state_q <= S_FRD;
					end
				end

				S_REPLY, S_HIT, S_DELIV: begin
					if (ack) begin
						state_q <= S_FIN;
					end
				end

				// Flush: read each queued datagram and look its hop up.
				S_FRD: begin
					if (qi_q < qcount_q) begin
						state_q <= S_FWAIT;
					end else begin
						qcount_q <= w_q;
						state_q  <= S_FIN;
					end
				end

				S_FWAIT: begin
					key_q      <= q_rdata[IP_W-1:0];
					fl_tag_q   <= q_rdata[QDW-1 -: QTW];
					mode_q     <= M_FLUSH;
					ci_q       <= '0;
					ck_vld_q   <= 1'b0;
					chit_q     <= 1'b0;
					cold_vld_q <= 1'b0;
					state_q    <= S_CSCAN;
				end

				// Send a resolved datagram or keep it, compacted in order.
				S_FDEC: begin
					if (fl_emit) begin
						if (ack) begin
							n_q     <= n_q + 1'b1;
							qi_q    <= qi_q + 1'b1;
							state_q <= S_FRD;
						end
					end else begin
						w_q     <= w_q + 1'b1;
						qi_q    <= qi_q + 1'b1;
						state_q <= S_FRD;
					end
				end

				S_FIN: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	arp_ram #(.WIDTH(CDW), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (ci_q[CIW-1:0]),
		.rdata (c_rdata)
	);

	arp_ram #(.WIDTH(RDW), .DEPTH(REQUEST_ENTRIES)) u_req_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (ri_q[RIW-1:0]),
		.rdata (r_rdata)
	);

	arp_ram #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (qi_q[QIW-1:0]),
		.rdata (q_rdata)
	);

	arp_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rin    (rin),
		.ack    (ack),
		.result (result)
	);

	// Checks on queue bookkeeping and time.
	`ARP_ASSERT_NOW(a_qcount_bound, clk, arst_n, 1'b1, qcount_q <= QCW'(QUEUE_DEPTH), "queue count beyond depth")
	`ARP_ASSERT_NOW(a_flush_order, clk, arst_n, state_q == S_FDEC, (w_q <= qi_q) && (qi_q < qcount_q), "flush write index passed read index")
	`ARP_ASSERT_NOW(a_result_limit, clk, arst_n, 1'b1, n_q <= NCNT_W'(MAX_RESULTS), "too many results for one item")
	`ARP_ASSERT_NEXT(a_tick_time, clk, arst_n, accept && (item.action == ACT_TICK), now_q == $past(now_q + TIME_W'(item.elapsed_ms)), "tick did not advance time")

endmodule

`default_nettype wire

// ----- hdl/arp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module arp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/arp_out.sv -----
// Result output stage: one staging register that waits for the last flag, then the
// output register that drives the result channel. Depends on arp_pkg and arp_if.
`timescale 1ns / 1ps
`default_nettype none

module arp_out import arp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire out_ctl_t ctl,
	input  wire res_t     rin,
	output logic          ack,
	arp_result_if.source  result
);

	logic stg_vld_q;
	res_t stg_q;
	logic out_vld_q;
	res_t out_q;
	logic ofree;
	logic move;

	// The staged beat leaves once the next one arrives or the item ends, and the output register is free.
	assign ofree = !out_vld_q || result.ready;
	assign ack   = !stg_vld_q || ofree;
	assign move  = stg_vld_q && ofree && (ctl.emit || ctl.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			stg_q     <= '0;
			out_q     <= '0;
		end else begin
			if (move) begin
				out_q     <= res_t'({stg_q[$bits(res_t)-1:1], ctl.fin});
				out_vld_q <= 1'b1;
			end else if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ctl.emit && ack) begin
				stg_q     <= rin;
				stg_vld_q <= 1'b1;
			end else if (ctl.fin && ack) begin
				stg_vld_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_vld_q;
	assign result.kind       = out_q.kind;
	assign result.dst_mac    = out_q.dst_mac;
	assign result.target_ip  = out_q.target_ip;
	assign result.target_mac = out_q.target_mac;
	assign result.out_tag    = out_q.out_tag;
	assign result.last       = out_q.last;

endmodule

`default_nettype wire
